@@ sv/wtsc_pkg.sv @@
// Package for the wave-table sound channel: types, codes, constants and helpers.
package wtsc_pkg;

    localparam int RAM_BYTES = 32;
    localparam int RAM_AW    = $clog2(RAM_BYTES);
    localparam int CLK_W     = 10;

    typedef enum logic [2:0] {
        M_TICK    = 3'd0,
        M_LENCLK  = 3'd1,
        M_REG_WR  = 3'd2,
        M_REG_RD  = 3'd3,
        M_RAM_WR  = 3'd4,
        M_RAM_RD  = 3'd5,
        M_DISABLE = 3'd6,
        M_LEN_RST = 3'd7
    } t_mode;

    localparam logic [3:0] REG_CTRL = 4'd0;
    localparam logic [3:0] REG_LEN  = 4'd1;
    localparam logic [3:0] REG_VOL  = 4'd2;
    localparam logic [3:0] REG_PLO  = 4'd3;
    localparam logic [3:0] REG_PHI  = 4'd4;

    typedef enum logic [2:0] {
        S_IDLE,
        S_STEP,
        S_FETCH,
        S_LEVEL,
        S_RAMRD,
        S_RAMCAP,
        S_EXEC,
        S_OUT
    } t_state;

    typedef struct packed {
        logic load;
        logic step;
        logic fetch;
        logic level;
        logic ram_rd;
        logic ram_cap;
        logic exec;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic playing;
        logic expire;
        logic rem_zero;
        logic clk_zero;
        logic out_free;
    } t_sts;

    // Scale a sample by the volume shift (shift code 0 mutes), or by 3/4 when forced.
    function automatic logic [3:0] scale_level(input logic [3:0] smp, input logic [1:0] sv,
                                               input logic ftq);
        logic [5:0] t;
        t = {2'b00, smp} + {1'b0, smp, 1'b0};
        if (ftq) scale_level = t[5:2];
        else if (sv == 2'd0) scale_level = 4'd0;
        else scale_level = smp >> (sv - 2'd1);
    endfunction

    // Timer reload, (2048 - period) * 2 in 13 bits.
    function automatic logic [12:0] reload_of(input logic [10:0] per);
        logic [11:0] d;
        d = 12'd2048 - {1'b0, per};
        reload_of = {d, 1'b0};
    endfunction

endpackage

@@ sv/wtsc_ram.sv @@
// Generic single-port RAM with registered read.
module wtsc_ram #(
    parameter int W = 8,
    parameter int D = 32
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [$clog2(D)-1:0] i_addr,
    input  logic [W-1:0]         i_wdata,
    output logic [W-1:0]         o_rdata
);
    logic [W-1:0] r_mem [D];

    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_addr] <= i_wdata;
        o_rdata <= r_mem[i_addr];
    end
endmodule

@@ sv/wtsc_ctrl.sv @@
// Controller state machine for the wave-table sound channel.
module wtsc_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  logic [2:0]      i_mode,
    input  wtsc_pkg::t_sts  i_sts,
    output logic            o_stall,
    output wtsc_pkg::t_cmd  o_cmd
);
    wtsc_pkg::t_state r_state, n_state;
    logic accept;

    assign accept = i_valid && (r_state == wtsc_pkg::S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= wtsc_pkg::S_IDLE;
        else r_state <= n_state;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            wtsc_pkg::S_IDLE: begin
                if (i_valid) begin
                    if (i_mode == wtsc_pkg::M_TICK)
                        n_state = i_sts.playing ? wtsc_pkg::S_STEP : wtsc_pkg::S_OUT;
                    else if (i_mode == wtsc_pkg::M_RAM_RD) n_state = wtsc_pkg::S_RAMRD;
                    else n_state = wtsc_pkg::S_EXEC;
                end
            end
            wtsc_pkg::S_STEP: begin
                if (i_sts.expire) n_state = wtsc_pkg::S_FETCH;
                else if (i_sts.rem_zero) n_state = wtsc_pkg::S_LEVEL;
            end
            wtsc_pkg::S_FETCH:
                n_state = i_sts.clk_zero ? wtsc_pkg::S_LEVEL : wtsc_pkg::S_STEP;
            wtsc_pkg::S_LEVEL:  n_state = wtsc_pkg::S_OUT;
            wtsc_pkg::S_RAMRD:  n_state = wtsc_pkg::S_RAMCAP;
            wtsc_pkg::S_RAMCAP: n_state = wtsc_pkg::S_OUT;
            wtsc_pkg::S_EXEC:   n_state = wtsc_pkg::S_OUT;
            wtsc_pkg::S_OUT:    if (i_sts.out_free) n_state = wtsc_pkg::S_IDLE;
            default:            n_state = wtsc_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd          = '0;
        o_cmd.load     = accept;
        o_cmd.step     = (r_state == wtsc_pkg::S_STEP);
        o_cmd.fetch    = (r_state == wtsc_pkg::S_FETCH);
        o_cmd.level    = (r_state == wtsc_pkg::S_LEVEL);
        o_cmd.ram_rd   = (r_state == wtsc_pkg::S_RAMRD);
        o_cmd.ram_cap  = (r_state == wtsc_pkg::S_RAMCAP);
        o_cmd.exec     = (r_state == wtsc_pkg::S_EXEC);
        o_cmd.out_load = (r_state == wtsc_pkg::S_OUT) && i_sts.out_free;
        o_stall        = (r_state != wtsc_pkg::S_IDLE);
    end
endmodule

@@ sv/wtsc_dp.sv @@
// Datapath for the wave-table sound channel: channel state, sample RAM, result register.
module wtsc_dp #(
    parameter int MAX_TICK_CLOCKS = 1023
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  wtsc_pkg::t_cmd i_cmd,
    input  logic [2:0]     i_mode,
    input  logic [9:0]     i_clock_count,
    input  logic [3:0]     i_address,
    input  logic [7:0]     i_write_data,
    input  logic           i_stall,
    output wtsc_pkg::t_sts o_sts,
    output logic           o_valid,
    output logic [7:0]     o_read_data,
    output logic [3:0]     o_sample_out,
    output logic [3:0]     o_output_level,
    output logic           o_channel_enabled
);
    localparam int CW = wtsc_pkg::CLK_W;
    localparam int AW = wtsc_pkg::RAM_AW;
    localparam logic [CW-1:0] SAT =
        (MAX_TICK_CLOCKS > 1023) ? {CW{1'b1}} : CW'(MAX_TICK_CLOCKS);

    logic r_play, r_dac, r_bank, r_two, r_ftq, r_lact, r_win, r_fired;
    logic [1:0]  r_sv;
    logic [10:0] r_per;
    logic [8:0]  r_len;
    logic [12:0] r_tmr;
    logic [5:0]  r_pos;
    logic [3:0]  r_held, r_lvl;
    logic [2:0]  r_mode;
    logic [CW-1:0] r_clk;
    logic [3:0]  r_addr;
    logic [7:0]  r_data, r_rd;
    logic [wtsc_pkg::RAM_BYTES-1:0] r_vld;
    logic        r_qv;

    logic [12:0] take, tmr_after;
    logic [CW-1:0] rem;
    logic [5:0]  pos_nx;
    logic [AW-1:0] fetch_idx, acc_idx, ram_addr;
    logic        allowed, ram_we;
    logic [7:0]  ram_q, byte_q;
    logic [10:0] per_hi;

    assign take      = ({3'b000, r_clk} < r_tmr) ? {3'b000, r_clk} : r_tmr;
    assign tmr_after = r_tmr - take;
    assign rem       = r_clk - take[CW-1:0];
    assign pos_nx    = r_two ? (r_pos + 6'd1) : {1'b0, r_pos[4:0] + 5'd1};
    assign fetch_idx = r_two ? pos_nx[5:1] : {r_bank, pos_nx[4:1]};
    assign acc_idx   = r_play ? r_pos[5:1] : {~r_bank, r_addr};
    assign allowed   = !r_play || r_win;
    assign ram_addr  = i_cmd.step ? fetch_idx : acc_idx;
    assign ram_we    = i_cmd.exec && (r_mode == wtsc_pkg::M_RAM_WR) && allowed;
    assign byte_q    = r_qv ? ram_q : 8'h00;
    assign per_hi    = {r_data[2:0], r_per[7:0]};

    wtsc_ram #(.W(8), .D(wtsc_pkg::RAM_BYTES)) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (r_data),
        .o_rdata (ram_q)
    );

    assign o_sts.playing  = r_play;
    assign o_sts.expire   = (tmr_after == 13'd0);
    assign o_sts.rem_zero = (rem == '0);
    assign o_sts.clk_zero = (r_clk == '0);
    assign o_sts.out_free = !o_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_play <= 1'b0; r_dac <= 1'b0; r_bank <= 1'b0; r_two <= 1'b0;
            r_sv <= 2'd0; r_ftq <= 1'b0; r_per <= '0; r_len <= '0; r_lact <= 1'b0;
            r_tmr <= '0; r_pos <= '0; r_held <= '0; r_lvl <= '0; r_win <= 1'b0;
            r_vld <= '0; r_fired <= 1'b0; o_valid <= 1'b0; r_qv <= 1'b0;
        end else begin
            r_qv <= r_vld[ram_addr];
            if (ram_we) r_vld[ram_addr] <= 1'b1;
            if (o_valid && !i_stall) o_valid <= 1'b0;
            if (i_cmd.load) begin
                r_mode  <= i_mode;
                r_clk   <= (i_clock_count > SAT) ? SAT : i_clock_count;
                r_addr  <= i_address;
                r_data  <= i_write_data;
                r_rd    <= 8'h00;
                r_fired <= 1'b0;
            end
            if (i_cmd.step) begin
                r_clk <= rem;
                if (tmr_after == 13'd0) begin
                    r_tmr   <= wtsc_pkg::reload_of(r_per);
                    r_pos   <= pos_nx;
                    r_fired <= 1'b1;
                    r_win   <= 1'b1;
                end else begin
                    r_tmr <= tmr_after;
                    r_win <= 1'b0;
                end
            end
            if (i_cmd.fetch) r_held <= r_pos[0] ? byte_q[3:0] : byte_q[7:4];
            if (i_cmd.level && r_fired) r_lvl <= wtsc_pkg::scale_level(r_held, r_sv, r_ftq);
            if (i_cmd.ram_cap) r_rd <= allowed ? byte_q : 8'hFF;
            if (i_cmd.exec) begin
                unique case (r_mode)
                    wtsc_pkg::M_LENCLK: begin
                        if (r_lact && r_len != 9'd0) begin
                            r_len <= r_len - 9'd1;
                            if (r_len == 9'd1) begin
                                r_play <= 1'b0;
                                r_lvl  <= 4'd0;
                            end
                        end
                    end
                    wtsc_pkg::M_REG_WR: begin
                        unique case (r_addr)
                            wtsc_pkg::REG_CTRL: begin
                                r_dac  <= r_data[7];
                                r_bank <= r_data[6];
                                r_two  <= r_data[5];
                                r_play <= r_play && r_data[7];
                            end
                            wtsc_pkg::REG_LEN: r_len <= 9'd256 - {1'b0, r_data};
                            wtsc_pkg::REG_VOL: begin
                                r_sv  <= r_data[6:5];
                                r_ftq <= r_data[7];
                                r_lvl <= wtsc_pkg::scale_level(r_held, r_data[6:5], r_data[7]);
                            end
                            wtsc_pkg::REG_PLO: r_per <= {r_per[10:8], r_data};
                            wtsc_pkg::REG_PHI: begin
                                r_per  <= per_hi;
                                r_lact <= r_data[6];
                                if (r_data[7]) begin
                                    r_play <= r_dac;
                                    if (r_dac) r_lvl <= wtsc_pkg::scale_level(r_held, r_sv, r_ftq);
                                    r_tmr <= wtsc_pkg::reload_of(per_hi) + 13'd6;
                                    if (r_len == 9'd0) r_len <= 9'd256;
                                    r_pos <= '0;
                                end
                            end
                            default: ;
                        endcase
                    end
                    wtsc_pkg::M_REG_RD: begin
                        unique case (r_addr)
                            wtsc_pkg::REG_CTRL: r_rd <= {r_dac, r_bank, r_two, 5'd0};
                            wtsc_pkg::REG_VOL:  r_rd <= {r_ftq, r_sv, 5'd0};
                            wtsc_pkg::REG_PHI:  r_rd <= {1'b0, r_lact, 6'd0};
                            default:            r_rd <= 8'h00;
                        endcase
                    end
                    wtsc_pkg::M_DISABLE: begin
                        r_play <= 1'b0; r_dac <= 1'b0; r_bank <= 1'b0; r_two <= 1'b0;
                        r_sv <= 2'd0; r_ftq <= 1'b0; r_per <= '0; r_lact <= 1'b0;
                        r_pos <= '0; r_held <= '0; r_lvl <= '0; r_tmr <= 13'd4096;
                    end
                    wtsc_pkg::M_LEN_RST: r_len <= '0;
                    default: ;
                endcase
            end
            if (i_cmd.out_load) o_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            o_read_data       <= r_rd;
            o_sample_out      <= r_play ? r_lvl : 4'd0;
            o_output_level    <= r_lvl;
            o_channel_enabled <= r_play;
        end
    end
endmodule

@@ sv/wave_table_sound_channel_core.sv @@
// Top level of the wave-table sound channel: controller, datapath and sample RAM.
//
//  channel | valid   | stall   | payload
//  --------+---------+---------+-------------------------------------------------
//  input   | i_valid | o_stall | i_mode, i_clock_count, i_address, i_write_data
//  result  | o_valid | i_stall | o_read_data, o_sample_out, o_output_level,
//          |         |         | o_channel_enabled
//
// Sequencing: one item at a time. A register, length, RAM write or disable item passes
// through the execute state, a RAM read through the read and capture states, a tick on
// a stopped channel straight to the output state, and a tick on a playing channel through
// the timer step loop (a sample RAM fetch after each timer expiry) and the level state.
// Reset: synchronous, active low; channel state and o_valid clear, and every RAM byte reads as zero
// until written (one valid bit per byte).
// Stalls: a finished result waits in the output register; the next item is taken
// once that result has been moved to the output register.
module wave_table_sound_channel_core #(
    parameter int MAX_TICK_CLOCKS = 1023
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [2:0] i_mode,
    input  logic [9:0] i_clock_count,
    input  logic [3:0] i_address,
    input  logic [7:0] i_write_data,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_read_data,
    output logic [3:0] o_sample_out,
    output logic [3:0] o_output_level,
    output logic       o_channel_enabled
);
    wtsc_pkg::t_cmd cmd;
    wtsc_pkg::t_sts sts;

    // Sequence each item: decode, step the timer and fetch, read the RAM or execute, then hand off the result.
    wtsc_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_mode  (i_mode),
        .i_sts   (sts),
        .o_stall (o_stall),
        .o_cmd   (cmd)
    );

    // Hold channel state, sample RAM and the result register.
    wtsc_dp #(.MAX_TICK_CLOCKS(MAX_TICK_CLOCKS)) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .i_mode            (i_mode),
        .i_clock_count     (i_clock_count),
        .i_address         (i_address),
        .i_write_data      (i_write_data),
        .i_stall           (i_stall),
        .o_sts             (sts),
        .o_valid           (o_valid),
        .o_read_data       (o_read_data),
        .o_sample_out      (o_sample_out),
        .o_output_level    (o_output_level),
        .o_channel_enabled (o_channel_enabled)
    );
endmodule
